FILE: design/rate_monotonic_dispatcher_core_assert.svh
// ---------------------------------------------------------------------------
// rate monotonic dispatcher assertion macros
// concurrent property shorthands used by the port checker
// ---------------------------------------------------------------------------
`ifndef RATE_MONOTONIC_DISPATCHER_CORE_ASSERT_SVH
`define RATE_MONOTONIC_DISPATCHER_CORE_ASSERT_SVH

// same-cycle implication under reset
`define RMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmd assertion failed");

// next-cycle implication under reset
`define RMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmd assertion failed");

`endif

FILE: design/rmd_pkg.sv
// ---------------------------------------------------------------------------
// rmd_pkg
// shared widths, codes and types of the rate monotonic dispatcher
// ---------------------------------------------------------------------------
package rmd_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int PERIOD_REGS    = 7;
    localparam int TIME_W         = 32;
    localparam int PERIOD_W       = 16;
    localparam int TASK_IDX_W     = 3;
    localparam int COUNT_W        = 4;
    localparam int MISS_W         = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int STEP_CNT_W     = 5;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_DONE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 3'd0;

    // entry zero is the idle entry and always reads zero
    typedef logic [PERIOD_REGS:0][PERIOD_W-1:0] period_array_t;

    typedef struct packed {
        logic done;
        logic zero;
    } mod_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_PICK,
        ST_DONE
    } state_t;

endpackage

FILE: design/rmd_in_if.sv
// ---------------------------------------------------------------------------
// rmd_in_if
// input channel: tick or completion transaction
// ---------------------------------------------------------------------------
interface rmd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [rmd_pkg::TIME_W-1:0]  time_now;
    logic [rmd_pkg::TASK_IDX_W-1:0] done_task;

    modport source (output valid, op, time_now, done_task, input ready);
    modport sink   (input valid, op, time_now, done_task, output ready);
endinterface

FILE: design/rmd_out_if.sv
// ---------------------------------------------------------------------------
// rmd_out_if
// output channel: chosen task and deadline-miss mask
// ---------------------------------------------------------------------------
interface rmd_out_if;
    logic                           valid;
    logic                           ready;
    logic [rmd_pkg::TASK_IDX_W-1:0] next_task;
    logic [rmd_pkg::MISS_W-1:0]     miss_mask;

    modport source (output valid, next_task, miss_mask, input ready);
    modport sink   (input valid, next_task, miss_mask, output ready);
endinterface

FILE: design/rate_monotonic_dispatcher_core.sv
// ---------------------------------------------------------------------------
// rate_monotonic_dispatcher_core
// periodic-task dispatcher with a shared bit-serial remainder unit
// ---------------------------------------------------------------------------
// in_ch carries one transaction per tick or task completion; out_ch returns
// exactly one transaction per input: the released task with the shortest
// period (ties to the lower index, 0 idle) and the deadline-miss mask.
// a tick walks tasks 1 .. min(task_count, TASK_SLOTS)-1 one at a time; each
// task with a nonzero period goes through the remainder unit (32 steps plus
// issue and check), zero-period tasks skip it. the choice is then made by a
// compare pass of one task per cycle; a completion goes straight to this
// pass. in_ch.ready is high only between transactions, from the cycle after
// the result is loaded. results sit in an output register, so a new input
// is taken while the last result waits; if the receiver stalls, the next
// result waits in the sequencer until the output register drains. reset
// clears the task count, the periods and all released flags. configuration
// is to be written only while the block is idle; the block itself does not
// enforce this.
// ---------------------------------------------------------------------------
module rate_monotonic_dispatcher_core #(
    parameter int TASK_SLOTS = rmd_pkg::TASK_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rmd_in_if.sink                         in_ch,
    rmd_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [rmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [rmd_pkg::COUNT_W-1:0] SLOTS = rmd_pkg::COUNT_W'(TASK_SLOTS);
    localparam logic [rmd_pkg::COUNT_W-1:0] FIRST_TASK = rmd_pkg::COUNT_W'(1);

    rmd_pkg::state_t                 state_reg, state_next;
    logic [rmd_pkg::COUNT_W-1:0]     idx_reg, idx_next;
    logic [rmd_pkg::TIME_W-1:0]      time_reg, time_next;
    logic [TASK_SLOTS-1:0]           flags_reg, flags_next;
    logic [rmd_pkg::MISS_W-1:0]      miss_reg, miss_next;
    logic [rmd_pkg::TASK_IDX_W-1:0]  best_reg, best_next;
    logic [rmd_pkg::PERIOD_W-1:0]    best_per_reg, best_per_next;
    logic                            out_valid_reg, out_valid_next;
    logic [rmd_pkg::TASK_IDX_W-1:0]  out_task_reg, out_task_next;
    logic [rmd_pkg::MISS_W-1:0]      out_miss_reg, out_miss_next;

    logic [rmd_pkg::COUNT_W-1:0]     task_count;
    rmd_pkg::period_array_t          periods;
    logic [rmd_pkg::COUNT_W-1:0]     limit;
    logic [rmd_pkg::PERIOD_W-1:0]    cur_period;
    logic                            cur_flag;
    logic                            idx_end;
    logic                            in_fire;
    logic                            out_free;
    logic                            mod_start;
    rmd_pkg::mod_status_t            mod_status;

    rmd_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .task_count (task_count),
        .periods    (periods)
    );

    rmd_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (time_reg),
        .divisor  (cur_period),
        .status   (mod_status)
    );

    assign limit      = (task_count > SLOTS) ? SLOTS : task_count;
    assign idx_end    = (idx_reg >= limit);
    assign cur_period = periods[idx_reg[rmd_pkg::TASK_IDX_W-1:0]];
    assign cur_flag   = flags_reg[idx_reg[IDX_W-1:0]];
    assign in_fire    = in_ch.valid && in_ch.ready;
    assign out_free   = !out_valid_reg || out_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (in_ch.op == rmd_pkg::OP_DONE) ? rmd_pkg::ST_PICK
                                                                : rmd_pkg::ST_SCAN;
                end
            end
            rmd_pkg::ST_SCAN:
            begin
                priority if (idx_end)
                    state_next = rmd_pkg::ST_PICK;
                else if (cur_period != '0)
                    state_next = rmd_pkg::ST_DIV;
            end
            rmd_pkg::ST_DIV:
            begin
                if (mod_status.done)
                    state_next = rmd_pkg::ST_SCAN;
            end
            rmd_pkg::ST_PICK:
            begin
                if (idx_end)
                    state_next = rmd_pkg::ST_DONE;
            end
            rmd_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = rmd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rmd_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and handshake
    always_comb
    begin
        idx_next       = idx_reg;
        time_next      = time_reg;
        flags_next     = flags_reg;
        miss_next      = miss_reg;
        best_next      = best_reg;
        best_per_next  = best_per_reg;
        out_task_next  = out_task_reg;
        out_miss_next  = out_miss_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        in_ch.ready    = 1'b0;
        mod_start      = 1'b0;
        unique case (state_reg)
            rmd_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_fire)
                begin
                    time_next     = in_ch.time_now;
                    idx_next      = FIRST_TASK;
                    miss_next     = '0;
                    best_next     = '0;
                    best_per_next = '0;
                    if (in_ch.op == rmd_pkg::OP_DONE &&
                        rmd_pkg::COUNT_W'(in_ch.done_task) < SLOTS)
                    begin
                        flags_next[in_ch.done_task[IDX_W-1:0]] = 1'b0;
                    end
                end
            end
            rmd_pkg::ST_SCAN:
            begin
                priority if (idx_end)
                    idx_next = FIRST_TASK;
                else if (cur_period != '0)
                    mod_start = 1'b1;
                else
                    idx_next = idx_reg + 1'b1;
            end
            rmd_pkg::ST_DIV:
            begin
                if (mod_status.done)
                begin
                    if (mod_status.zero)
                    begin
                        if (cur_flag)
                            miss_next[idx_reg[rmd_pkg::TASK_IDX_W-1:0]] = 1'b1;
                        flags_next[idx_reg[IDX_W-1:0]] = 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            rmd_pkg::ST_PICK:
            begin
                if (!idx_end)
                begin
                    if (cur_flag && (best_reg == '0 || cur_period < best_per_reg))
                    begin
                        best_next     = idx_reg[rmd_pkg::TASK_IDX_W-1:0];
                        best_per_next = cur_period;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            rmd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_task_next  = best_reg;
                    out_miss_next  = miss_reg;
                end
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmd_pkg::ST_IDLE;
            idx_reg       <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg     <= time_next;
        miss_reg     <= miss_next;
        best_reg     <= best_next;
        best_per_reg <= best_per_next;
        out_task_reg <= out_task_next;
        out_miss_reg <= out_miss_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.next_task = out_task_reg;
    assign out_ch.miss_mask = out_miss_reg;

endmodule

FILE: design/rmd_cfg_regs.sv
// ---------------------------------------------------------------------------
// rmd_cfg_regs
// task count and period registers behind the plain write port
// ---------------------------------------------------------------------------
module rmd_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rmd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic [rmd_pkg::COUNT_W-1:0]        task_count,
    output rmd_pkg::period_array_t             periods
);

    logic [rmd_pkg::COUNT_W-1:0] task_count_reg;
    rmd_pkg::period_array_t      periods_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
            periods_reg    <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rmd_pkg::REG_TASK_COUNT)
            begin
                task_count_reg <= cfg_wdata[rmd_pkg::COUNT_W-1:0];
            end
            else
            begin
                periods_reg[cfg_index] <= cfg_wdata[rmd_pkg::PERIOD_W-1:0];
            end
        end
    end

    assign task_count = task_count_reg;
    assign periods    = periods_reg;

endmodule

FILE: design/rmd_mod_unit.sv
// ---------------------------------------------------------------------------
// rmd_mod_unit
// bit-serial restoring remainder, one dividend bit per cycle
// ---------------------------------------------------------------------------
module rmd_mod_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rmd_pkg::TIME_W-1:0]        dividend,
    input  logic [rmd_pkg::PERIOD_W-1:0]      divisor,
    output rmd_pkg::mod_status_t              status
);

    localparam logic [rmd_pkg::STEP_CNT_W-1:0] LAST_STEP = rmd_pkg::STEP_CNT_W'(rmd_pkg::TIME_W - 1);

    logic [rmd_pkg::PERIOD_W-1:0]   rem_reg, rem_next;
    logic [rmd_pkg::TIME_W-1:0]     dvd_reg, dvd_next;
    logic [rmd_pkg::PERIOD_W-1:0]   div_reg, div_next;
    logic [rmd_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           run_reg, run_next;
    logic                           done_reg, done_next;
    logic [rmd_pkg::PERIOD_W:0]     trial;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[rmd_pkg::TIME_W-1]};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            div_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so the difference fits
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = rmd_pkg::PERIOD_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[rmd_pkg::PERIOD_W-1:0];
            end
            dvd_next = {dvd_reg[rmd_pkg::TIME_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

FILE: design/rmd_checker.sv
// ---------------------------------------------------------------------------
// rmd_checker
// port-level checks of the dispatcher, bound to the top level
// ---------------------------------------------------------------------------
`include "rate_monotonic_dispatcher_core_assert.svh"

module rmd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [rmd_pkg::TASK_IDX_W-1:0] next_task,
    input logic [rmd_pkg::MISS_W-1:0]     miss_mask
);

    // a result waits until it is taken
    `RMD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // a waiting result keeps its fields
    `RMD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
        $stable(next_task) && $stable(miss_mask))

    // one transaction in flight: no accept in the cycle after an accept
    `RMD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // the idle entry never reports a deadline miss
    `RMD_ASSERT_IMPLY(a_no_idle_miss, clk, rst_n, out_valid, !miss_mask[0])

    // a result cannot appear in the cycle right after an accept
    `RMD_ASSERT_NEXT(a_min_latency, clk, rst_n,
        in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind rate_monotonic_dispatcher_core rmd_checker u_rmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .next_task (out_ch.next_task),
    .miss_mask (out_ch.miss_mask)
);

FILE: sim/tb_rate_monotonic_dispatcher_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_rate_monotonic_dispatcher_core
// self-checking bench: a directed table covering reset, extremes and corner
// cases of release, miss and completion, then randomized configuration
// phases with tick/completion traffic, sender bursts, receiver stalls and a
// long output hold-off; each result is compared against a typed row's values
// or a software scheduler model kept in step with each accepted transaction
// ---------------------------------------------------------------------------
module tb_rate_monotonic_dispatcher_core;

    localparam int CFG_IDX_W      = rmd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = rmd_pkg::CFG_DATA_W;
    localparam int TASK_IDX_W     = rmd_pkg::TASK_IDX_W;
    localparam int MISS_W         = rmd_pkg::MISS_W;
    localparam int TIME_W         = rmd_pkg::TIME_W;
    localparam int COUNT_W        = rmd_pkg::COUNT_W;
    localparam int PERIOD_W       = rmd_pkg::PERIOD_W;
    localparam int PERIOD_REGS    = rmd_pkg::PERIOD_REGS;
    localparam int TASK_SLOTS_DEF = rmd_pkg::TASK_SLOTS_DEF;

    localparam logic OP_TICK = rmd_pkg::OP_TICK;
    localparam logic OP_DONE = rmd_pkg::OP_DONE;

    localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = rmd_pkg::REG_TASK_COUNT;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 7;
    localparam int RAND_PHASES    = 13;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_PHASE     = 6;
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 300;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD7 = 3'd7;

    typedef struct packed {
        logic [TASK_IDX_W-1:0] next_task;
        logic [MISS_W-1:0]     miss_mask;
    } dispatch_t;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_STRIDE
    } rx_mode_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  op;
        logic [TIME_W-1:0]     now;
        logic [TASK_IDX_W-1:0] done;
        logic                  typed;
        logic [TASK_IDX_W-1:0] t_next;
        logic [MISS_W-1:0]     t_miss;
    } stim_row_t;

    localparam int DIR_ROWS = 32;
    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        // straight out of reset: no task in use
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'd0, 3'd0, 1'b1, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_DONE, 32'd0, 3'd7, 1'b1, 3'd0, 8'h00},
        // count of one considers nothing
        '{ROW_CFG,  REG_TASK_COUNT, 16'd1, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_CFG,  REG_PERIOD1,    16'd1, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'd0, 3'd0, 1'b1, 3'd0, 8'h00},
        // full table, one zero period, one maximum period
        '{ROW_CFG,  REG_TASK_COUNT, 16'd8, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_CFG,  REG_PERIOD1,    16'd4, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_CFG,  REG_PERIOD2,    16'd0, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_CFG,  REG_PERIOD3,    16'd2, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_CFG,  REG_PERIOD4, 16'hFFFF, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_CFG,  REG_PERIOD5,    16'd6, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_CFG,  REG_PERIOD6,    16'd4, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_CFG,  REG_PERIOD7,    16'd1, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'hFFFF_FFFF, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'd0, 3'd5, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'd12, 3'd0, 1'b0, 3'd0, 8'h00},
        // completions walk down the choice, tie goes to the lower index
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_DONE, 32'd0, 3'd7, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_DONE, 32'd0, 3'd3, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_DONE, 32'd0, 3'd1, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_DONE, 32'hFFFF_FFFF, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'd1, 3'd7, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'd1, 3'd0, 1'b0, 3'd0, 8'h00},
        // released task whose period drops to zero
        '{ROW_CFG,  REG_PERIOD7,    16'd0, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'd3, 3'd0, 1'b0, 3'd0, 8'h00},
        // shrink the table, upper flags go stale
        '{ROW_CFG,  REG_TASK_COUNT, 16'd4, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'd5, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'd2, 3'd0, 1'b0, 3'd0, 8'h00},
        // oversized count acts as the full table
        '{ROW_CFG,  REG_TASK_COUNT, 16'd15, OP_TICK, 32'd0, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_DONE, 32'd0, 3'd3, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'd65535, 3'd0, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_DONE, 32'd0, 3'd7, 1'b0, 3'd0, 8'h00},
        '{ROW_ITEM, REG_TASK_COUNT, 16'd0, OP_TICK, 32'h8000_0000, 3'd0, 1'b0, 3'd0, 8'h00}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rmd_in_if  in_ch ();
    rmd_out_if out_ch ();

    rate_monotonic_dispatcher_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // scheduler model state
    logic [COUNT_W-1:0]  task_cnt_m;
    logic [PERIOD_W-1:0] period_m [0:PERIOD_REGS];
    logic                rel_flag [0:TASK_SLOTS_DEF-1];

    dispatch_t pending_picks [$];
    int        err_cnt = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;
    bit        hold_req = 1'b0;

    function automatic int active_span();
        int n;
        n = task_cnt_m;
        if (n > TASK_SLOTS_DEF)
        begin
            n = TASK_SLOTS_DEF;
        end
        return n;
    endfunction

    function automatic dispatch_t predict_dispatch(input logic op,
                                                   input logic [TIME_W-1:0] now,
                                                   input logic [TASK_IDX_W-1:0] done);
        dispatch_t res;
        int        span;
        span = active_span();
        res  = '0;
        if (op == OP_TICK)
        begin
            for (int t = 1; t < span; t++)
            begin
                if (period_m[t] != 0 && (now % {16'd0, period_m[t]}) == 0)
                begin
                    if (rel_flag[t])
                    begin
                        res.miss_mask[t] = 1'b1;
                    end
                    rel_flag[t] = 1'b1;
                end
            end
        end
        else
        begin
            rel_flag[done] = 1'b0;
        end
        for (int t = 1; t < span; t++)
        begin
            if (rel_flag[t] && (res.next_task == 0 || period_m[t] < period_m[res.next_task]))
            begin
                res.next_task = TASK_IDX_W'(t);
            end
        end
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == REG_TASK_COUNT)
        begin
            task_cnt_m = val[COUNT_W-1:0];
        end
        else
        begin
            period_m[idx] = val;
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        if (burst_left != 0)
        begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
        end
        do
        begin
            @(posedge clk);
        end
        while (pending_picks.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic offer_item(input logic op, input logic [TIME_W-1:0] now,
                              input logic [TASK_IDX_W-1:0] done, input logic typed,
                              input logic [TASK_IDX_W-1:0] t_next,
                              input logic [MISS_W-1:0] t_miss);
        dispatch_t want;
        int        gap;
        if (burst_left == 0)
        begin
            // valid is already low here, so the wait below leaves a gap in the offers
            gap = $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(9, 40);
            end
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.time_now  <= now;
        in_ch.done_task <= done;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        want = predict_dispatch(op, now, done);
        if (typed)
        begin
            want.next_task = t_next;
            want.miss_mask = t_miss;
        end
        pending_picks.push_back(want);
        burst_left--;
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        dispatch_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_picks.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual next_task %0d miss_mask %02h",
                         $time, out_ch.next_task, out_ch.miss_mask);
                err_cnt++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (out_ch.next_task !== want.next_task)
                begin
                    $display("%0t: next_task mismatch, expected %0d actual %0d",
                             $time, want.next_task, out_ch.next_task);
                    err_cnt++;
                end
                if (out_ch.miss_mask !== want.miss_mask)
                begin
                    $display("%0t: miss_mask mismatch, expected %02h actual %02h",
                             $time, want.miss_mask, out_ch.miss_mask);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("rate_monotonic_dispatcher_core verification failed");
                $finish;
            end
        end
    end

    // receiver: stall patterns, plus one long hold-off on request
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       rx_tick;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        rx_tick   = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_tick++;
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ch.ready <= ($urandom_range(0, 7) == 0);
                    default:   out_ch.ready <= (rx_tick % 4 == 0);
                endcase
            end
        end
    end

    // stimulus
    initial
    begin
        logic [COUNT_W-1:0]    cnt;
        logic [CFG_DATA_W-1:0] cword;
        logic [PERIOD_W-1:0]   per;
        logic [TIME_W-1:0]     now;
        logic [TIME_W-1:0]     clock_m;
        logic [TASK_IDX_W-1:0] done;
        int                    sel;
        int                    span;
        int                    live [$];

        in_ch.valid     <= 1'b0;
        in_ch.op        <= OP_TICK;
        in_ch.time_now  <= '0;
        in_ch.done_task <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_TASK_COUNT;
        cfg_wdata       <= '0;
        rst_n           <= 1'b0;
        task_cnt_m = '0;
        for (int t = 0; t <= PERIOD_REGS; t++)
        begin
            period_m[t] = '0;
        end
        for (int t = 0; t < TASK_SLOTS_DEF; t++)
        begin
            rel_flag[t] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIR_TAB[r].kind == ROW_CFG)
            begin
                if (r == 0 || DIR_TAB[r-1].kind != ROW_CFG)
                begin
                    settle();
                end
                write_reg(DIR_TAB[r].reg_idx, DIR_TAB[r].reg_val);
                if (r == DIR_ROWS - 1 || DIR_TAB[r+1].kind != ROW_CFG)
                begin
                    cfg_we <= 1'b0;
                end
            end
            else
            begin
                offer_item(DIR_TAB[r].op, DIR_TAB[r].now, DIR_TAB[r].done,
                           DIR_TAB[r].typed, DIR_TAB[r].t_next, DIR_TAB[r].t_miss);
            end
        end

        clock_m = $urandom;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            settle();
            if (ph == 1)
            begin
                cnt = 4'd0;
            end
            else if (ph == 2)
            begin
                cnt = 4'd1;
            end
            else if (ph == 3)
            begin
                cnt = 4'd15;
            end
            else if (ph == 0 || ph == 4)
            begin
                cnt = 4'd8;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                cnt = 4'($urandom_range(0, 15));
            end
            else
            begin
                cnt = 4'($urandom_range(2, 8));
            end
            cword = {12'h000, cnt};
            // junk in the unused upper bits now and then
            if (ph % 4 == 3)
            begin
                cword[CFG_DATA_W-1:COUNT_W] = 12'($urandom);
            end
            write_reg(REG_TASK_COUNT, cword);
            for (int t = 1; t <= PERIOD_REGS; t++)
            begin
                sel = $urandom_range(0, 9);
                if (ph == 0)
                begin
                    per = 16'($urandom_range(1, 8));
                end
                else if (ph == 4)
                begin
                    per = 16'hFFFF;
                end
                else if (sel == 0)
                begin
                    per = 16'd0;
                end
                else if (sel == 1)
                begin
                    per = 16'hFFFF;
                end
                else if (sel == 2)
                begin
                    per = 16'($urandom_range(1, 65535));
                end
                else
                begin
                    per = 16'($urandom_range(1, 16));
                end
                write_reg(REG_PERIOD1 + CFG_IDX_W'(t - 1), per);
            end
            cfg_we <= 1'b0;
            if (ph == HOLD_PHASE)
            begin
                hold_req = 1'b1;
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 55)
                begin
                    sel = $urandom_range(0, 19);
                    if (sel < 13)
                    begin
                        now = clock_m;
                        clock_m++;
                    end
                    else if (sel < 16)
                    begin
                        // land on a multiple of one of the periods
                        per = period_m[$urandom_range(1, PERIOD_REGS)];
                        now = 32'(per) * 32'($urandom_range(0, 65536));
                    end
                    else if (sel < 18)
                    begin
                        now = $urandom;
                    end
                    else
                    begin
                        now = 32'hFFFF_FFFF - 32'($urandom_range(0, 20));
                    end
                    offer_item(OP_TICK, now, 3'($urandom), 1'b0, 3'd0, 8'h00);
                end
                else
                begin
                    live.delete();
                    span = active_span();
                    for (int t = 1; t < span; t++)
                    begin
                        if (rel_flag[t])
                        begin
                            live.push_back(t);
                        end
                    end
                    if (live.size() != 0 && $urandom_range(0, 9) < 7)
                    begin
                        done = 3'(live[$urandom_range(0, live.size() - 1)]);
                    end
                    else
                    begin
                        done = 3'($urandom_range(0, 7));
                    end
                    offer_item(OP_DONE, $urandom, done, 1'b0, 3'd0, 8'h00);
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0 && pending_picks.size() == 0)
        begin
            $display("rate_monotonic_dispatcher_core verification clean");
        end
        else
        begin
            $display("rate_monotonic_dispatcher_core verification failed");
        end
        $finish;
    end

endmodule
